@@ sv/criticality_aware_lru_replacement_unit_defines.svh @@
`ifndef CRITICALITY_AWARE_LRU_REPLACEMENT_UNIT_DEFINES_SVH
`define CRITICALITY_AWARE_LRU_REPLACEMENT_UNIT_DEFINES_SVH

// Checked on every rising clock edge outside reset.
`define CARLRU_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Condition in one cycle implies consequence in the next.
`define CARLRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/carlru_pkg.sv @@
package carlru_pkg;

  localparam int NUM_SETS    = 1024;
  localparam int NUM_WAYS    = 16;
  localparam int CRIT_BITS   = 8;
  localparam int QUEUE_DEPTH = 2;

  localparam int SET_W  = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
  localparam int RANK_W = $clog2(NUM_WAYS);
  localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [1:0] {
    FUNC_QUERY = 2'd0,
    FUNC_HIT   = 2'd1,
    FUNC_FILL  = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    OP_QUERY,
    OP_QUERY_ZERO,
    OP_TOUCH,
    OP_FILL
  } op_e;

  typedef logic [SET_W-1:0]     set_t;
  typedef logic [RANK_W-1:0]    rank_t;
  typedef logic [CRIT_BITS-1:0] crit_t;

  typedef struct packed {
    op_e   op;
    set_t  set;
    rank_t way;
    crit_t crit;
  } req_t;

  typedef struct packed {
    rank_t [NUM_WAYS-1:0] rank;
    crit_t [NUM_WAYS-1:0] crit;
  } row_t;

  function automatic row_t reset_row();
    row_t r;
    for (int w = 0; w < NUM_WAYS; w++) begin
      r.rank[w] = RANK_W'(w);
      r.crit[w] = '0;
    end
    return r;
  endfunction

endpackage

@@ sv/carlru_front.sv @@
module carlru_front (
  input  logic              start_i,
  input  logic              busy_i,
  input  logic [1:0]        func_i,
  input  logic [9:0]        set_index_i,
  input  logic [3:0]        way_index_i,
  input  logic [7:0]        new_crit_i,
  input  logic              is_writeback_i,
  output logic              push_o,
  output carlru_pkg::req_t  req_o
);
  import carlru_pkg::*;

  logic set_ok;
  logic way_ok;
  logic keep;

  assign set_ok = 32'(set_index_i) < NUM_SETS;
  assign way_ok = 32'(way_index_i) < NUM_WAYS;

  always_comb begin
    keep   = 1'b0;
    req_o.op   = OP_TOUCH;
    req_o.set  = SET_W'(set_index_i);
    req_o.way  = RANK_W'(way_index_i);
    req_o.crit = CRIT_BITS'(new_crit_i);
    unique case (func_i)
      FUNC_QUERY: begin
        keep     = 1'b1;
        req_o.op = set_ok ? OP_QUERY : OP_QUERY_ZERO;
      end
      FUNC_HIT: begin
        keep     = set_ok && way_ok && !is_writeback_i;
        req_o.op = OP_TOUCH;
      end
      FUNC_FILL: begin
        keep     = set_ok && way_ok;
        req_o.op = OP_FILL;
      end
      default: begin
        keep     = 1'b0;
        req_o.op = OP_TOUCH;
      end
    endcase
  end

  assign push_o     = start_i && !busy_i && keep;

endmodule

@@ sv/carlru_fifo.sv @@
`include "criticality_aware_lru_replacement_unit_defines.svh"

module carlru_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  carlru_pkg::req_t  push_data_i,
  input  logic              pop_i,
  output carlru_pkg::req_t  head_o,
  output logic              empty_o,
  output logic              full_o
);
  import carlru_pkg::*;

  req_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d;
  logic [QPTR_W-1:0] rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign head_o  = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  `CARLRU_ASSERT(a_no_push_full, push_i |-> !full_o, "push into full queue")
  `CARLRU_ASSERT(a_no_pop_empty, pop_i |-> !empty_o, "pop from empty queue")

endmodule

@@ sv/carlru_back.sv @@
`include "criticality_aware_lru_replacement_unit_defines.svh"

module carlru_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  carlru_pkg::req_t  head_i,
  input  logic              empty_i,
  output logic              pop_o,
  output logic              clearing_o,
  output logic              valid_o,
  output logic [3:0]        victim_way_o
);
  import carlru_pkg::*;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e        state_q;
  set_t          clr_q;
  req_t          cur_q;
  logic          valid_q;
  rank_t         victim_q;

  row_t          mem_q [NUM_SETS];
  row_t          rdata_q;

  logic          we;
  set_t          waddr;
  row_t          wdata;

  logic [NUM_WAYS-1:0] qual;
  logic [NUM_WAYS-1:0] cand;
  logic [NUM_WAYS-1:0] present;
  rank_t               rmax;
  rank_t               victim;
  rank_t               touched;
  row_t                upd;

  assign pop_o      = (state_q == S_IDLE) && !empty_i;
  assign clearing_o = (state_q == S_CLEAR);

  always_comb begin
    for (int w = 0; w < NUM_WAYS; w++) begin
      qual[w] = rdata_q.crit[w] >= cur_q.crit;
    end
    cand = (|qual) ? qual : '1;
    for (int r = 0; r < NUM_WAYS; r++) begin
      present[r] = 1'b0;
      for (int w = 0; w < NUM_WAYS; w++) begin
        if (cand[w] && rdata_q.rank[w] == RANK_W'(r)) begin
          present[r] = 1'b1;
        end
      end
    end
    rmax = '0;
    for (int r = 0; r < NUM_WAYS; r++) begin
      if (present[r]) begin
        rmax = RANK_W'(r);
      end
    end
    victim = '0;
    for (int w = NUM_WAYS - 1; w >= 0; w--) begin
      if (cand[w] && rdata_q.rank[w] == rmax) begin
        victim = RANK_W'(w);
      end
    end
  end

  always_comb begin
    touched = rdata_q.rank[cur_q.way];
    upd     = rdata_q;
    for (int w = 0; w < NUM_WAYS; w++) begin
      if (rdata_q.rank[w] <= touched) begin
        upd.rank[w] = rdata_q.rank[w] + 1'b1;
      end
    end
    upd.rank[cur_q.way] = '0;
    if (cur_q.op == OP_FILL) begin
      upd.crit[cur_q.way] = cur_q.crit;
    end
  end

  always_comb begin
    we    = 1'b0;
    waddr = cur_q.set;
    wdata = upd;
    if (state_q == S_CLEAR) begin
      we    = 1'b1;
      waddr = clr_q;
      wdata = reset_row();
    end else if (state_q == S_EXEC) begin
      we = (cur_q.op == OP_TOUCH) || (cur_q.op == OP_FILL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (pop_o) begin
      rdata_q <= mem_q[head_i.set];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_CLEAR;
      clr_q    <= '0;
      valid_q  <= 1'b0;
      victim_q <= '0;
    end else begin
      valid_q <= 1'b0;
      unique case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == SET_W'(NUM_SETS - 1)) begin
            state_q <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty_i) begin
            state_q <= S_EXEC;
          end
        end
        S_EXEC: begin
          state_q <= S_IDLE;
          if (cur_q.op == OP_QUERY) begin
            valid_q  <= 1'b1;
            victim_q <= victim;
          end else if (cur_q.op == OP_QUERY_ZERO) begin
            valid_q  <= 1'b1;
            victim_q <= '0;
          end
        end
        default: begin
          state_q <= S_CLEAR;
        end
      endcase
    end
  end

  assign valid_o      = valid_q;
  assign victim_way_o = 4'(victim_q);

  `CARLRU_ASSERT_NEXT(a_exec_once, state_q == S_EXEC, state_q == S_IDLE, "exec not one cycle")
  `CARLRU_ASSERT(a_valid_after_exec, valid_q |-> $past(state_q == S_EXEC), "stray result")
  `CARLRU_ASSERT(a_no_pop_clear, clearing_o |-> !pop_o && !valid_q, "activity during clear")

endmodule

@@ sv/criticality_aware_lru_replacement_unit.sv @@
// Criticality-aware LRU replacement state for a 1024-set, 16-way cache. Pulse start
// while busy is low to issue a victim query, a hit update or a fill update. Queries
// return exactly one victim_way_o with a one-cycle valid_o pulse that cannot be
// stalled; updates return nothing. After reset the block sweeps all 1024 set rows
// to their reset values and holds busy high during the sweep. Each request then
// passes through the back end as one row read, then a compare and row write on the
// single-port set memory; the back end takes no new request until the last is done.
// valid_o is registered and rises as the back end leaves the compare step of
// its query; items waiting ahead in the queue delay it. A 2-entry queue between
// the front and the back end absorbs short bursts; busy is high while it is full.
module criticality_aware_lru_replacement_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] func_i,
  input  logic [9:0] set_index_i,
  input  logic [3:0] way_index_i,
  input  logic [7:0] new_crit_i,
  input  logic       is_writeback_i,
  output logic       valid_o,
  output logic [3:0] victim_way_o
);
  import carlru_pkg::*;

  logic push;
  req_t req;
  req_t head;
  logic empty;
  logic full;
  logic pop;
  logic clearing;

  assign busy = clearing || full;

  carlru_front u_front (
    .start_i        (start),
    .busy_i         (busy),
    .func_i         (func_i),
    .set_index_i    (set_index_i),
    .way_index_i    (way_index_i),
    .new_crit_i     (new_crit_i),
    .is_writeback_i (is_writeback_i),
    .push_o         (push),
    .req_o          (req)
  );

  carlru_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (req),
    .pop_i       (pop),
    .head_o      (head),
    .empty_o     (empty),
    .full_o      (full)
  );

  carlru_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .empty_i      (empty),
    .pop_o        (pop),
    .clearing_o   (clearing),
    .valid_o      (valid_o),
    .victim_way_o (victim_way_o)
  );

endmodule
